[hdl/ffpa_pkg.sv]
// Shared constants for the first-fit pool allocator.
`default_nettype none
package ffpa_pkg;
   localparam int unsigned POOL_GRANULES_DEF = 1024;
   localparam int unsigned GRANULE_BYTES_DEF = 32;
   localparam int unsigned CFG_W = 11;
   localparam int unsigned BYTES_W = 16;
   localparam int unsigned OFFSET_W = 15;
   localparam int unsigned STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE = 1'b1;
endpackage
`default_nettype wire

[hdl/ffpa_ram.sv]
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
`default_nettype none
module ffpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/first_fit_pool_allocator.sv]
// Top level of the first-fit pool allocator: chain walker over a header RAM.
//
//  channel | dir | fields
//  req_    | in  | tdata: request_bytes[15:0], release_offset[30:16]; tuser: kind
//  rsp_    | out | tdata: status[1:0], payload_offset[16:2]
//  csr_    | in  | wdata: pool_granules[10:0]
//
// Each request walks the cell chain, reading each header from the RAM and then
// deciding on it, as the header RAM has a registered read. After the walk, an
// allocation may write the split header, and a free may merge with the next and
// previous cells, before the result is valid.
// reset, or a csr_ write, first writes the header of granule 0; requests wait.
// rsp_tvalid holds until taken; no new item is taken while a result waits, and
// the block returns to idle after each result before it takes the next item.
`default_nettype none
module first_fit_pool_allocator #(
   parameter int unsigned POOL_GRANULES = ffpa_pkg::POOL_GRANULES_DEF,
   parameter int unsigned GRANULE_BYTES = ffpa_pkg::GRANULE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // request_bytes, release_offset, pad
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // status, payload_offset, pad
   input  wire logic        csr_wen,
   input  wire logic [10:0] csr_wdata   // pool_granules
);
   import ffpa_pkg::*;

   localparam int unsigned GW = $clog2(POOL_GRANULES);
   localparam int unsigned SW = GW + 1;
   localparam int unsigned HW = SW + 1;
   localparam int unsigned CW = (GW + 2 > CFG_W + 1) ? GW + 2 : CFG_W + 1;
   localparam int unsigned BS = $clog2(GRANULE_BYTES);

   localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2,
      ST_DEC = 4'd3, ST_SPLIT = 4'd4, ST_NXRD = 4'd5, ST_NXDEC = 4'd6,
      ST_PVRD = 4'd7, ST_PVDEC = 4'd8, ST_DONE = 4'd9, ST_WRG = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] end_ff, end_in;        // end granule
   logic [CW-1:0] g_ff, g_in;            // current cell
   logic [CW-1:0] prev_ff, prev_in;
   logic has_prev_ff, has_prev_in;
   logic kind_ff, kind_in;
   logic [CW-1:0] need_ff, need_in;
   logic need_big_ff, need_big_in;       // need does not fit any cell
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [SW-1:0] gsize_ff, gsize_in;    // size of the allocated cell, or of the freed cell after merge
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [OFFSET_W-1:0] po_ff, po_in;
   logic pend_init_ff, pend_init_in;
   logic [CFG_W-1:0] cfg_ff, cfg_in;

   logic wr_en;
   logic [GW-1:0] wr_addr, rd_addr;
   logic [HW-1:0] wr_data, rd_data;
   logic [SW-1:0] rd_size;
   logic rd_used;

   ffpa_ram #(.WIDTH(HW), .DEPTH(POOL_GRANULES)) u_hdr (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );
   assign rd_size = rd_data[SW-1:0];
   assign rd_used = rd_data[SW];

   logic [CW-1:0] cfg_sat;
   logic [CW-1:0] nxt;
   logic [CW:0] need_full;
   logic [BYTES_W-1:0] rb;
   logic [CW+BS:0] pay_full;

   always_comb begin
      cfg_sat = (CW'(cfg_ff) > CW'(POOL_GRANULES)) ? CW'(POOL_GRANULES) : CW'(cfg_ff);
      nxt = g_ff + CW'(1) + CW'(rd_size);
      rb = req_tdata[BYTES_W-1:0];
      need_full = (CW+1)'((BYTES_W+1)'(rb) + (BYTES_W+1)'(GRANULE_BYTES - 1) >> BS);
      pay_full = (CW+BS+1)'(g_ff + CW'(1)) << BS;
   end

   always_comb begin
      state_in = state_ff; end_in = end_ff; g_in = g_ff; prev_in = prev_ff;
      has_prev_in = has_prev_ff; kind_in = kind_ff; need_in = need_ff;
      need_big_in = need_big_ff; off_in = off_ff; gsize_in = gsize_ff;
      st_in = st_ff; po_in = po_ff; pend_init_in = pend_init_ff; cfg_in = cfg_ff;
      wr_en = 1'b0; wr_addr = g_ff[GW-1:0]; wr_data = '0; rd_addr = g_ff[GW-1:0];
      req_tready = 1'b0;
      if (csr_wen) begin
         cfg_in = csr_wdata;
         pend_init_in = 1'b1;
      end
      case (state_ff)
         ST_INIT: begin
            // Only granule 0 matters for a fresh chain.
            wr_en = 1'b1; wr_addr = '0;
            if (cfg_sat >= CW'(3)) begin
               wr_data = {1'b0, SW'(cfg_sat - CW'(2))};
               end_in = cfg_sat - CW'(1);
            end else begin
               end_in = '0;
            end
            if (!csr_wen) begin
               pend_init_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pend_init_ff) begin
               state_in = ST_INIT;
            end else begin
               req_tready = !csr_wen;
               if (req_tvalid && !csr_wen) begin
                  kind_in = req_tuser;
                  off_in = req_tdata[BYTES_W +: OFFSET_W];
                  need_in = need_full[CW-1:0];
                  need_big_in = need_full[CW];
                  g_in = '0; has_prev_in = 1'b0;
                  st_in = (req_tuser == KIND_FREE) ? STATUS_NOTFOUND : STATUS_NOFIT;
                  po_in = '0;
                  if (req_tuser == KIND_ALLOC && rb == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            if (g_ff >= end_ff || g_ff >= CW'(POOL_GRANULES)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (kind_ff == KIND_ALLOC) begin
               if (!rd_used && !need_big_ff && CW'(rd_size) >= need_ff) begin
                  st_in = STATUS_OK; po_in = pay_full[OFFSET_W-1:0];
                  wr_en = 1'b1;
                  gsize_in = rd_size;
                  if ((CW+1)'(rd_size) >= (CW+1)'(need_ff) + (CW+1)'(2) &&
                      g_ff + CW'(1) + need_ff < CW'(POOL_GRANULES)) begin
                     wr_data = {1'b1, SW'(need_ff)};
                     state_in = ST_SPLIT;
                  end else begin
                     wr_data = {1'b1, rd_size};
                     state_in = ST_DONE;
                  end
               end else begin
                  g_in = nxt; state_in = ST_RD;
               end
            end else begin
               if ((CW+BS+1)'(off_ff) == pay_full) begin
                  st_in = STATUS_OK;
                  gsize_in = rd_size;
                  wr_en = 1'b1; wr_data = {1'b0, rd_size};
                  // hold the next cell's granule in need for the next-cell merge read
                  need_in = nxt;
                  state_in = ST_NXRD;
               end else begin
                  prev_in = g_ff; has_prev_in = 1'b1;
                  g_in = nxt; state_in = ST_RD;
               end
            end
         end
         ST_SPLIT: begin
            wr_en = 1'b1;
            wr_addr = GW'(g_ff + CW'(1) + need_ff);
            wr_data = {1'b0, SW'(CW'(gsize_ff) - need_ff - CW'(1))};
            state_in = ST_DONE;
         end
         ST_NXRD: begin
            rd_addr = need_ff[GW-1:0];
            if (need_ff < end_ff && need_ff < CW'(POOL_GRANULES)) begin
               state_in = ST_NXDEC;
            end else begin
               state_in = ST_PVRD;
            end
         end
         ST_NXDEC: begin
            if (!rd_used) begin
               gsize_in = SW'(gsize_ff + rd_size + SW'(1));
               state_in = ST_WRG;
            end else begin
               state_in = ST_PVRD;
            end
         end
         ST_WRG: begin
            wr_en = 1'b1; wr_data = {1'b0, gsize_ff};
            state_in = ST_PVRD;
         end
         ST_PVRD: begin
            rd_addr = prev_ff[GW-1:0];
            state_in = has_prev_ff ? ST_PVDEC : ST_DONE;
         end
         ST_PVDEC: begin
            if (!rd_used) begin
               wr_en = 1'b1; wr_addr = prev_ff[GW-1:0];
               wr_data = {1'b0, SW'(rd_size + gsize_ff + SW'(1))};
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pend_init_ff <= 1'b0;
         cfg_ff <= CFG_W'(1024);
      end else begin
         state_ff <= state_in;
         pend_init_ff <= pend_init_in;
         cfg_ff <= cfg_in;
      end
      end_ff <= end_in; g_ff <= g_in; prev_ff <= prev_in; has_prev_ff <= has_prev_in;
      kind_ff <= kind_in; need_ff <= need_in; need_big_ff <= need_big_in;
      off_ff <= off_in; gsize_ff <= gsize_in; st_ff <= st_in; po_ff <= po_in;
   end

   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata = {5'd0, po_ff, st_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("item taken while result waits");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != STATUS_OK |-> po_ff == '0)
      else $error("offset on failed request");
endmodule
`default_nettype wire
